@@ rtl/core/prq_pkg.sv @@
// ----------------------------------------------------------------------------
// Priority ready queue scheduler package
// Shared types, constants and opcodes for the scheduler core.
// ----------------------------------------------------------------------------
package prq_pkg;

   localparam int TaskSlots = 16;
   localparam int PriorityLevels = 32;
   localparam int SlotW = 4;
   localparam int LevelW = 5;

   typedef enum logic [1:0] {
      OP_CREATE   = 2'd0,
      OP_RESUME   = 2'd1,
      OP_SET_PRIO = 2'd2,
      OP_SCHEDULE = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      STS_OK       = 2'd0,
      STS_FULL     = 2'd1,
      STS_BAD_PRIO = 2'd2,
      STS_UNKNOWN  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      TS_READY   = 2'd0,
      TS_RUNNING = 2'd1,
      TS_BLOCKED = 2'd2
   } task_state_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic [3:0] task_id;
      logic [7:0] priority_req;
      logic       create_blocked;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  result_task;
      logic [31:0] dispatch_total;
      logic [31:0] ready_levels;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_ENQ,
      S_SEARCH,
      S_DEQ,
      S_UNLINK,
      S_WALK,
      S_RELINK,
      S_DISPATCH,
      S_DONE
   } state_type;

endpackage

@@ rtl/core/prq_level_search.sv @@
// ----------------------------------------------------------------------------
// Level search unit
// Steps down from the top level one level per cycle to the highest set bit.
// ----------------------------------------------------------------------------
module prq_level_search (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       go,
   input  logic [31:0]                mask,
   output logic                       done,
   output logic [prq_pkg::LevelW-1:0] level
);
   import prq_pkg::*;

   logic                busy_ff, busy_in;
   logic [LevelW-1:0]   lvl_ff, lvl_in;

   always_comb begin
      busy_in = busy_ff;
      lvl_in  = lvl_ff;
      if (go) begin
         busy_in = 1'b1;
         lvl_in  = LevelW'(PriorityLevels - 1);
      end else if (busy_ff) begin
         if (mask[lvl_ff] || lvl_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            lvl_in = lvl_ff - 1'b1;
         end
      end
   end

   assign done  = busy_ff && (mask[lvl_ff] || lvl_ff == '0);
   assign level = lvl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      lvl_ff <= lvl_in;
   end
endmodule

@@ rtl/core/priority_ready_queue_scheduler.sv @@
// ----------------------------------------------------------------------------
// Priority ready queue scheduler: one FIFO list per level and a bitmap of levels.
// Create, resume and rejected commands: decode, an optional enqueue, then the strobe;
// schedule adds a level search and dispatch; set priority walks one link per cycle.
// Commands are taken one at a time, in idle only. Reset clears mask, slots, running task.
// ----------------------------------------------------------------------------
module priority_ready_queue_scheduler (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  prq_pkg::req_type req_cmd,
   output logic             rsp_strobe,
   output prq_pkg::rsp_type rsp_data
);
   import prq_pkg::*;

   state_type state_ff, state_in;
   req_type   cmd_ff, cmd_in;

   logic [31:0]       mask_ff, mask_in;
   logic [SlotW-1:0]  head_ff [PriorityLevels];
   logic [SlotW-1:0]  tail_ff [PriorityLevels];
   logic [SlotW-1:0]  next_ff [TaskSlots];
   logic [LevelW-1:0] tlvl_ff [TaskSlots];
   logic [1:0]        tsts_ff [TaskSlots];
   logic [31:0]       cnt_ff  [TaskSlots];
   logic [SlotW:0]    used_ff, used_in;
   logic [SlotW-1:0]  run_ff, run_in;
   logic              runv_ff, runv_in;

   // enqueue target and follow-up state
   logic [SlotW-1:0]  enq_ff, enq_in;
   state_type         after_ff, after_in;
   logic [SlotW-1:0]  cur_ff, cur_in;
   logic [SlotW-1:0]  pick_ff, pick_in;
   logic [4:0]        walk_ff, walk_in;
   logic [1:0]        sts_ff, sts_in;
   logic [SlotW-1:0]  res_ff, res_in;
   logic [31:0]       rcnt_ff, rcnt_in;

   logic              srch_go, srch_done;
   logic [LevelW-1:0] srch_lvl;

   prq_level_search u_search (
      .clock (clock), .reset (reset), .go (srch_go), .mask (mask_ff),
      .done (srch_done), .level (srch_lvl)
   );

   logic [LevelW-1:0] enq_lvl, ul_lvl;
   logic              id_ok, prio_ok;
   assign enq_lvl = tlvl_ff[enq_ff];
   assign ul_lvl  = tlvl_ff[cmd_ff.task_id];
   assign id_ok   = {1'b0, cmd_ff.task_id} < used_ff;
   assign prio_ok = cmd_ff.priority_req < 8'(PriorityLevels);

   // next-state logic
   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      mask_in  = mask_ff;
      used_in  = used_ff;
      run_in   = run_ff;
      runv_in  = runv_ff;
      enq_in   = enq_ff;
      after_in = after_ff;
      cur_in   = cur_ff;
      pick_in  = pick_ff;
      walk_in  = walk_ff;
      sts_in   = sts_ff;
      res_in   = res_ff;
      rcnt_in  = rcnt_ff;
      srch_go  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in   = req_cmd;
               sts_in   = STS_OK;
               res_in   = '0;
               rcnt_in  = '0;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            after_in = S_DONE;
            state_in = S_DONE;
            case (opcode_type'(cmd_ff.opcode))
               OP_CREATE: begin
                  if (used_ff >= (SlotW+1)'(TaskSlots)) begin
                     sts_in = STS_FULL;
                  end else if (!prio_ok) begin
                     sts_in = STS_BAD_PRIO;
                  end else begin
                     used_in = used_ff + 1'b1;
                     res_in  = used_ff[SlotW-1:0];
                     enq_in  = used_ff[SlotW-1:0];
                     if (!cmd_ff.create_blocked) state_in = S_ENQ;
                  end
               end
               OP_RESUME: begin
                  if (!id_ok) begin
                     sts_in = STS_UNKNOWN;
                  end else if (tsts_ff[cmd_ff.task_id] == TS_BLOCKED) begin
                     enq_in   = cmd_ff.task_id;
                     state_in = S_ENQ;
                  end
               end
               OP_SET_PRIO: begin
                  if (!id_ok) begin
                     sts_in = STS_UNKNOWN;
                  end else if (!prio_ok) begin
                     sts_in = STS_BAD_PRIO;
                  end else if (tsts_ff[cmd_ff.task_id] == TS_READY) begin
                     state_in = S_UNLINK;
                  end
               end
               default: begin
                  after_in = S_SEARCH;
                  if (runv_ff && tsts_ff[run_ff] == TS_RUNNING) begin
                     enq_in   = run_ff;
                     state_in = S_ENQ;
                  end else begin
                     state_in = S_SEARCH;
                  end
               end
            endcase
         end
         S_ENQ: begin
            mask_in[enq_lvl] = 1'b1;
            state_in = after_ff;
         end
         S_SEARCH: begin
            if (mask_ff == '0) begin
               if (runv_ff) begin
                  pick_in  = run_ff;
                  state_in = S_DISPATCH;
               end else begin
                  sts_in   = STS_UNKNOWN;
                  state_in = S_DONE;
               end
            end else begin
               srch_go  = 1'b1;
               state_in = S_DEQ;
            end
         end
         S_DEQ: begin
            if (srch_done) begin
               pick_in = head_ff[srch_lvl];
               if (head_ff[srch_lvl] == tail_ff[srch_lvl]) mask_in[srch_lvl] = 1'b0;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            run_in   = pick_ff;
            runv_in  = 1'b1;
            res_in   = pick_ff;
            rcnt_in  = cnt_ff[pick_ff] + 32'd1;
            state_in = S_DONE;
         end
         S_UNLINK: begin
            cur_in   = head_ff[ul_lvl];
            walk_in  = '0;
            state_in = S_RELINK;
            if (mask_ff[ul_lvl]) begin
               if (head_ff[ul_lvl] == cmd_ff.task_id) begin
                  if (tail_ff[ul_lvl] == cmd_ff.task_id) mask_in[ul_lvl] = 1'b0;
               end else begin
                  state_in = S_WALK;
               end
            end
         end
         S_WALK: begin
            // advance one link per cycle looking for the predecessor
            if (cur_ff == tail_ff[ul_lvl] || walk_ff == 5'(TaskSlots)
                || next_ff[cur_ff] == cmd_ff.task_id) begin
               state_in = S_RELINK;
            end else begin
               cur_in  = next_ff[cur_ff];
               walk_in = walk_ff + 1'b1;
            end
         end
         S_RELINK: begin
            enq_in   = cmd_ff.task_id;
            after_in = S_DONE;
            state_in = S_ENQ;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // table updates follow the same sequencing
   logic walk_hit;
   assign walk_hit = !(cur_ff == tail_ff[ul_lvl]) && walk_ff != 5'(TaskSlots)
                     && next_ff[cur_ff] == cmd_ff.task_id;

   always_ff @(posedge clock) begin
      case (state_ff)
         S_DECODE: begin
            if (cmd_ff.opcode == OP_CREATE && used_ff < (SlotW+1)'(TaskSlots) && prio_ok) begin
               tlvl_ff[used_ff[SlotW-1:0]] <= cmd_ff.priority_req[LevelW-1:0];
               cnt_ff[used_ff[SlotW-1:0]]  <= '0;
               next_ff[used_ff[SlotW-1:0]] <= '0;
               tsts_ff[used_ff[SlotW-1:0]] <= TS_BLOCKED;
            end
         end
         S_ENQ: begin
            tsts_ff[enq_ff] <= TS_READY;
            if (mask_ff[enq_lvl]) begin
               next_ff[tail_ff[enq_lvl]] <= enq_ff;
            end else begin
               head_ff[enq_lvl] <= enq_ff;
            end
            tail_ff[enq_lvl] <= enq_ff;
         end
         S_DEQ: begin
            if (srch_done && head_ff[srch_lvl] != tail_ff[srch_lvl])
               head_ff[srch_lvl] <= next_ff[head_ff[srch_lvl]];
         end
         S_DISPATCH: begin
            tsts_ff[pick_ff] <= TS_RUNNING;
            cnt_ff[pick_ff]  <= cnt_ff[pick_ff] + 32'd1;
         end
         S_UNLINK: begin
            if (mask_ff[ul_lvl] && head_ff[ul_lvl] == cmd_ff.task_id
                && tail_ff[ul_lvl] != cmd_ff.task_id)
               head_ff[ul_lvl] <= next_ff[cmd_ff.task_id];
         end
         S_WALK: begin
            if (walk_hit) begin
               if (tail_ff[ul_lvl] == cmd_ff.task_id) tail_ff[ul_lvl] <= cur_ff;
               else next_ff[cur_ff] <= next_ff[cmd_ff.task_id];
            end
         end
         S_RELINK: begin
            tlvl_ff[cmd_ff.task_id] <= cmd_ff.priority_req[LevelW-1:0];
         end
         default: ;
      endcase
      if (state_ff == S_DECODE && cmd_ff.opcode == OP_SET_PRIO && id_ok && prio_ok
          && tsts_ff[cmd_ff.task_id] != TS_READY)
         tlvl_ff[cmd_ff.task_id] <= cmd_ff.priority_req[LevelW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mask_ff  <= '0;
         used_ff  <= '0;
         runv_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         mask_ff  <= mask_in;
         used_ff  <= used_in;
         runv_ff  <= runv_in;
      end
      cmd_ff   <= cmd_in;
      run_ff   <= run_in;
      enq_ff   <= enq_in;
      after_ff <= after_in;
      cur_ff   <= cur_in;
      pick_ff  <= pick_in;
      walk_ff  <= walk_in;
      sts_ff   <= sts_in;
      res_ff   <= res_in;
      rcnt_ff  <= rcnt_in;
   end

   // output logic
   always_comb begin
      busy       = state_ff != S_IDLE;
      rsp_strobe = state_ff == S_DONE;
      rsp_data.status         = sts_ff;
      rsp_data.result_task    = res_ff;
      rsp_data.dispatch_total = rcnt_ff;
      rsp_data.ready_levels   = mask_ff;
   end

`ifndef SYNTHESIS
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy) else $error("strobe while idle");
   a_one_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("double strobe");
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= (SlotW+1)'(TaskSlots)) else $error("slot count overflow");
   a_sched_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && cmd_ff.opcode == OP_SCHEDULE && sts_ff == STS_OK) |-> runv_ff)
      else $error("schedule ok without running task");
`endif
endmodule

@@ dv/tb_priority_ready_queue_scheduler.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Priority ready queue scheduler testbench
// Drives create, resume, set-priority and schedule commands, predicts every
// response from a behavioral copy of the per-level FIFO lists and checks
// each strobed response field by field.
// ----------------------------------------------------------------------------
module tb_priority_ready_queue_scheduler;
   import prq_pkg::*;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_cmd;
   logic    rsp_strobe;
   rsp_type rsp_data;

   priority_ready_queue_scheduler u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_cmd    (req_cmd),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // scheduler shadow state
   logic [31:0] lvl_mask;
   logic [3:0]  lvl_head [PriorityLevels];
   logic [3:0]  lvl_tail [PriorityLevels];
   logic [3:0]  nxt_slot [TaskSlots];
   logic [4:0]  slot_lvl [TaskSlots];
   task_state_type slot_state [TaskSlots];
   logic [31:0] slot_runs [TaskSlots];
   int          num_slots;
   logic [3:0]  cur_slot;
   logic        cur_valid;

   req_type pending_cmds [$];
   rsp_type expected_rsps [$];
   int      err_count = 0;
   int      send_gap;
   logic    hold_until_drained;

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
      err_count++;
   endtask

   function automatic void queue_tail(input logic [3:0] t);
      logic [4:0] p;
      p = slot_lvl[t];
      slot_state[t] = TS_READY;
      if (lvl_mask[p]) begin
         nxt_slot[lvl_tail[p]] = t;
         lvl_tail[p] = t;
      end else begin
         lvl_head[p] = t;
         lvl_tail[p] = t;
      end
      lvl_mask[p] = 1'b1;
   endfunction

   function automatic void unlink(input logic [3:0] t);
      logic [4:0] p;
      logic [3:0] c;
      p = slot_lvl[t];
      if (!lvl_mask[p]) return;
      if (lvl_head[p] == t) begin
         if (lvl_tail[p] == t) lvl_mask[p] = 1'b0;
         else lvl_head[p] = nxt_slot[t];
         return;
      end
      c = lvl_head[p];
      for (int n = 0; n < TaskSlots && c != lvl_tail[p]; n++) begin
         if (nxt_slot[c] == t) begin
            if (lvl_tail[p] == t) lvl_tail[p] = c;
            else nxt_slot[c] = nxt_slot[t];
            return;
         end
         c = nxt_slot[c];
      end
   endfunction

   function automatic rsp_type predict_response(input req_type r);
      rsp_type o;
      logic [3:0] t;
      logic found;
      int p;
      o = '0;
      case (opcode_type'(r.opcode))
         OP_CREATE: begin
            if (num_slots >= TaskSlots) o.status = STS_FULL;
            else if (r.priority_req >= PriorityLevels) o.status = STS_BAD_PRIO;
            else begin
               t = num_slots[3:0];
               num_slots++;
               slot_lvl[t] = r.priority_req[4:0];
               slot_runs[t] = '0;
               nxt_slot[t] = '0;
               if (r.create_blocked) slot_state[t] = TS_BLOCKED;
               else queue_tail(t);
               o.result_task = t;
            end
         end
         OP_RESUME: begin
            if (r.task_id >= num_slots) o.status = STS_UNKNOWN;
            else if (slot_state[r.task_id] == TS_BLOCKED) queue_tail(r.task_id);
         end
         OP_SET_PRIO: begin
            if (r.task_id >= num_slots) o.status = STS_UNKNOWN;
            else if (r.priority_req >= PriorityLevels) o.status = STS_BAD_PRIO;
            else if (slot_state[r.task_id] == TS_READY) begin
               unlink(r.task_id);
               slot_lvl[r.task_id] = r.priority_req[4:0];
               queue_tail(r.task_id);
            end else slot_lvl[r.task_id] = r.priority_req[4:0];
         end
         default: begin
            if (cur_valid && slot_state[cur_slot] == TS_RUNNING) queue_tail(cur_slot);
            found = 1'b0;
            if (lvl_mask != 0) begin
               p = PriorityLevels - 1;
               while (p > 0 && !lvl_mask[p]) p--;
               t = lvl_head[p];
               if (t == lvl_tail[p]) lvl_mask[p] = 1'b0;
               else lvl_head[p] = nxt_slot[t];
               found = 1'b1;
            end else if (cur_valid) begin
               t = cur_slot;
               found = 1'b1;
            end
            if (!found) o.status = STS_UNKNOWN;
            else begin
               slot_state[t] = TS_RUNNING;
               cur_slot = t;
               cur_valid = 1'b1;
               slot_runs[t] = slot_runs[t] + 32'd1;
               o.result_task = t;
               o.dispatch_total = slot_runs[t];
            end
         end
      endcase
      o.ready_levels = lvl_mask;
      return o;
   endfunction

   function automatic req_type make_cmd(input opcode_type op, input int id,
                                        input int pr, input bit susp);
      req_type r;
      r.opcode = op;
      r.task_id = id[3:0];
      r.priority_req = pr[7:0];
      r.create_blocked = susp;
      return r;
   endfunction

   // Mostly legal priorities; a few out of range and full-width values.
   function automatic int rand_prio();
      case ($urandom_range(0, 9))
         0: return $urandom_range(32, 255);
         1: return 255 - $urandom_range(0, 3);
         default: return $urandom_range(0, 31);
      endcase
   endfunction

   // Driver: hold start until the transfer, then wait a random gap.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_cmd <= '0;
         send_gap <= 0;
         lvl_mask = '0;
         num_slots = 0;
         cur_slot = '0;
         cur_valid = 1'b0;
         for (int i = 0; i < PriorityLevels; i++) begin
            lvl_head[i] = '0;
            lvl_tail[i] = '0;
         end
         for (int i = 0; i < TaskSlots; i++) begin
            nxt_slot[i] = '0;
            slot_lvl[i] = '0;
            slot_state[i] = TS_READY;
            slot_runs[i] = '0;
         end
      end else if (start && !busy) begin
         start <= 1'b0;
         send_gap <= $urandom_range(0, 1) ? 0 : $urandom_range(0, 16);
         expected_rsps.push_back(predict_response(req_cmd));
      end else if (!start) begin
         if (send_gap > 0) send_gap <= send_gap - 1;
         else if (hold_until_drained && expected_rsps.size() != 0) begin
         end else if (pending_cmds.size() != 0) begin
            req_cmd <= pending_cmds.pop_front();
            start <= 1'b1;
         end
      end
   end

   // Monitor: compare every strobed response with the oldest prediction.
   always @(posedge clock) begin
      rsp_type w;
      if (!reset && rsp_strobe) begin
         if (expected_rsps.size() == 0) begin
            $display("unexpected response at %0t", $time);
            err_count++;
         end else begin
            w = expected_rsps.pop_front();
            if (rsp_data.status !== w.status)
               report("status", 32'(rsp_data.status), 32'(w.status));
            if (rsp_data.result_task !== w.result_task)
               report("result_task", 32'(rsp_data.result_task), 32'(w.result_task));
            if (rsp_data.dispatch_total !== w.dispatch_total)
               report("dispatch_total", rsp_data.dispatch_total, w.dispatch_total);
            if (rsp_data.ready_levels !== w.ready_levels)
               report("ready_levels", rsp_data.ready_levels, w.ready_levels);
         end
      end
   end

   initial begin
      int k;
      reset = 1'b1;
      hold_until_drained = 1'b0;

      // Directed: empty schedule, unknown ids, bad priority, extremes.
      pending_cmds.push_back(make_cmd(OP_SCHEDULE, 0, 0, 0));
      pending_cmds.push_back(make_cmd(OP_RESUME, 15, 0, 0));
      pending_cmds.push_back(make_cmd(OP_SET_PRIO, 0, 5, 0));
      pending_cmds.push_back(make_cmd(OP_CREATE, 15, 255, 1));
      pending_cmds.push_back(make_cmd(OP_CREATE, 0, 32, 0));
      pending_cmds.push_back(make_cmd(OP_CREATE, 0, 0, 0));
      pending_cmds.push_back(make_cmd(OP_CREATE, 0, 31, 1));
      pending_cmds.push_back(make_cmd(OP_CREATE, 0, 31, 0));
      pending_cmds.push_back(make_cmd(OP_SCHEDULE, 0, 0, 0));
      pending_cmds.push_back(make_cmd(OP_SCHEDULE, 0, 0, 0));
      pending_cmds.push_back(make_cmd(OP_RESUME, 1, 0, 0));
      pending_cmds.push_back(make_cmd(OP_RESUME, 1, 0, 0));
      pending_cmds.push_back(make_cmd(OP_SET_PRIO, 1, 31, 0));
      pending_cmds.push_back(make_cmd(OP_SET_PRIO, 0, 0, 0));
      pending_cmds.push_back(make_cmd(OP_SET_PRIO, 2, 255, 0));
      pending_cmds.push_back(make_cmd(OP_SET_PRIO, 2, 7, 0));
      pending_cmds.push_back(make_cmd(OP_SCHEDULE, 0, 0, 0));
      pending_cmds.push_back(make_cmd(OP_SCHEDULE, 0, 0, 0));
      for (int i = 0; i < 14; i++)
         pending_cmds.push_back(make_cmd(OP_CREATE, 0, i * 2, i[0]));
      pending_cmds.push_back(make_cmd(OP_SET_PRIO, 3, 4, 0));

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      while (pending_cmds.size() != 0 || start || expected_rsps.size() != 0)
         @(posedge clock);

      // Random traffic on a full pool, first draining each response, then without waiting.
      hold_until_drained = 1'b1;
      for (k = 0; k < 600; k++)
         pending_cmds.push_back(make_cmd(opcode_type'($urandom_range(0, 3)),
            $urandom_range(0, 15), rand_prio(), $urandom_range(0, 1)));
      while (pending_cmds.size() != 0 || start || expected_rsps.size() != 0)
         @(posedge clock);
      hold_until_drained = 1'b0;
      for (k = 0; k < 600; k++)
         pending_cmds.push_back(make_cmd(opcode_type'($urandom_range(0, 3)),
            $urandom_range(0, 15), rand_prio(), $urandom_range(0, 1)));
      while (pending_cmds.size() != 0 || start || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
      if (err_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #20000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
